/* hdl/valve_peak_hold_driver_assert.svh */
// Assertion macros for the valve peak-and-hold driver.
// Used by the port checker; needs clk_i and rst_ni in scope where used.
`ifndef VALVE_PEAK_HOLD_DRIVER_ASSERT_SVH
`define VALVE_PEAK_HOLD_DRIVER_ASSERT_SVH

// Clocked check that is ignored while reset is asserted.
`define VPHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define VPHD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/vphd_pkg.sv */
// Shared types and constants of the valve peak-and-hold driver.
// Used by every RTL module of the block; depends on nothing.
package vphd_pkg;

  localparam int unsigned NUM_VALVES = 7;
  localparam int unsigned NUM_PORTS  = 5;

  localparam logic [7:0]  FULL_DUTY = 8'hFF;
  localparam logic [15:0] AGE_MAX   = 16'hFFFF;

  localparam logic [7:0]  HOLD_DUTY_RESET = 8'd255;
  localparam logic [15:0] THRESHOLD_RESET = 16'd500;

  // Pump numbers accepted by a pump write.
  localparam logic [1:0] PUMP1_INDEX = 2'd1;
  localparam logic [1:0] PUMP2_INDEX = 2'd2;

  // Register index as decoded from paddr[2].
  localparam logic REG_HOLD_DUTY = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SET_PORTS = 3'd1,
    OP_OPEN      = 3'd2,
    OP_CLOSE     = 3'd3,
    OP_PUMP      = 3'd4
  } op_e;

  typedef struct packed {
    logic [7:0]  hold_duty;
    logic [15:0] threshold_ms;
  } cfg_t;

  typedef struct packed {
    op_e        op;
    logic [6:0] valve_mask;
    logic [1:0] pump_index;
    logic [7:0] pump_duty;
  } item_t;

  // Packed with the last field in the lowest bits, matching m_axis_tdata.
  typedef struct packed {
    logic [7:0] pump2_level;
    logic [7:0] pump1_level;
    logic [7:0] outlet_duty;
    logic [7:0] inlet_duty;
    logic [7:0] port5_duty;
    logic [7:0] port4_duty;
    logic [7:0] port3_duty;
    logic [7:0] port2_duty;
    logic [7:0] port1_duty;
    logic [6:0] hold_mask;
    logic [8:0] status_bits;
  } result_t;

endpackage

/* hdl/vphd_cfg_regs.sv */
// Configuration registers of the valve driver behind an APB-style port.
// Depends on vphd_pkg for the register layout and reset values.
module vphd_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [2:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  output logic [31:0]         prdata_o,
  output logic                pready_o,
  output vphd_pkg::cfg_t      cfg_o
);

  logic        wr_en;
  logic [7:0]  hold_duty_q;
  logic [15:0] threshold_q;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;

  // Register writes; the register is picked by the word address bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_duty_q <= vphd_pkg::HOLD_DUTY_RESET;
      threshold_q <= vphd_pkg::THRESHOLD_RESET;
    end else if (wr_en) begin
      if (paddr_i[2] == vphd_pkg::REG_HOLD_DUTY) begin
        hold_duty_q <= pwdata_i[7:0];
      end else begin
        threshold_q <= pwdata_i[15:0];
      end
    end
  end

  // Read-back mux.
  always_comb begin
    if (paddr_i[2] == vphd_pkg::REG_THRESHOLD) begin
      prdata_o = {16'd0, threshold_q};
    end else begin
      prdata_o = {24'd0, hold_duty_q};
    end
  end

  assign cfg_o.hold_duty    = hold_duty_q;
  assign cfg_o.threshold_ms = threshold_q;

endmodule

/* hdl/vphd_core.sv */
// Valve and pump state with its combinational update and result logic.
// Depends on vphd_pkg for the request, result and configuration types.
module vphd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  vphd_pkg::item_t   item_i,
  input  vphd_pkg::cfg_t    cfg_i,
  output vphd_pkg::result_t result_o
);

  localparam int unsigned NV = vphd_pkg::NUM_VALVES;
  localparam int unsigned NP = vphd_pkg::NUM_PORTS;

  logic [NV-1:0] open_q, open_d;
  logic [NV-1:0] held_q, held_d;
  logic [15:0]   age_q [NV];
  logic [15:0]   age_d [NV];
  logic [7:0]    pump_q [2];
  logic [7:0]    pump_d [2];
  logic [7:0]    duty   [NV];

  // Next state for the request being processed.
  always_comb begin
    open_d = open_q;
    held_d = held_q;
    age_d  = age_q;
    pump_d = pump_q;
    case (item_i.op)
      vphd_pkg::OP_TICK: begin
        // Saturating age count, then the hold check on the new age.
        for (int i = 0; i < NV; i++) begin
          if (open_q[i]) begin
            if (age_q[i] != vphd_pkg::AGE_MAX) begin
              age_d[i] = age_q[i] + 16'd1;
            end
            if (age_d[i] > cfg_i.threshold_ms) begin
              held_d[i] = 1'b1;
            end
          end
        end
      end
      vphd_pkg::OP_SET_PORTS: begin
        // Every port valve is rewritten: opened or closed, age cleared.
        for (int i = 0; i < NP; i++) begin
          age_d[i] = 16'd0;
        end
        open_d[NP-1:0] = item_i.valve_mask[NP-1:0];
        held_d[NP-1:0] = '0;
      end
      vphd_pkg::OP_OPEN: begin
        for (int i = 0; i < NV; i++) begin
          if (item_i.valve_mask[i]) begin
            age_d[i] = 16'd0;
          end
        end
        open_d = open_q | item_i.valve_mask;
        held_d = held_q & ~item_i.valve_mask;
      end
      vphd_pkg::OP_CLOSE: begin
        for (int i = 0; i < NV; i++) begin
          if (item_i.valve_mask[i]) begin
            age_d[i] = 16'd0;
          end
        end
        open_d = open_q & ~item_i.valve_mask;
        held_d = held_q & ~item_i.valve_mask;
      end
      vphd_pkg::OP_PUMP: begin
        if (item_i.pump_index == vphd_pkg::PUMP1_INDEX) begin
          pump_d[0] = item_i.pump_duty;
        end else if (item_i.pump_index == vphd_pkg::PUMP2_INDEX) begin
          pump_d[1] = item_i.pump_duty;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers, written only when a request moves to the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
      held_q <= '0;
      for (int i = 0; i < NV; i++) begin
        age_q[i] <= 16'd0;
      end
      pump_q[0] <= 8'd0;
      pump_q[1] <= 8'd0;
    end else if (advance_i) begin
      open_q <= open_d;
      held_q <= held_d;
      age_q  <= age_d;
      pump_q <= pump_d;
    end
  end

  // Drive duty per valve: off, hold level or full level.
  always_comb begin
    for (int i = 0; i < NV; i++) begin
      if (!open_d[i]) begin
        duty[i] = 8'd0;
      end else if (held_d[i]) begin
        duty[i] = cfg_i.hold_duty;
      end else begin
        duty[i] = vphd_pkg::FULL_DUTY;
      end
    end
  end

  // Result as seen after the update.
  assign result_o.status_bits = {pump_d[1] != 8'd0, pump_d[0] != 8'd0, open_d};
  assign result_o.hold_mask   = held_d & open_d;
  assign result_o.port1_duty  = duty[0];
  assign result_o.port2_duty  = duty[1];
  assign result_o.port3_duty  = duty[2];
  assign result_o.port4_duty  = duty[3];
  assign result_o.port5_duty  = duty[4];
  assign result_o.inlet_duty  = duty[5];
  assign result_o.outlet_duty = duty[6];
  assign result_o.pump1_level = pump_d[0];
  assign result_o.pump2_level = pump_d[1];

endmodule

/* hdl/valve_peak_hold_driver.sv */
// Valve peak-and-hold driver: seven solenoid valves and two pumps.
// A request waits in the input register; its result goes to the result register.
// Throughput: one request per cycle while the result stream is not stalled; the state update
// is a single pass between the input register and the result register.
// Reset (rst_ni, async, low): all valves closed and not held, ages and pumps
// zero, hold_duty 255, threshold_ms 500, both stream registers empty.
module valve_peak_hold_driver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // valve_mask[6:0], pump_index[8:7], pump_duty[16:9]
  input  logic [2:0]  s_axis_tuser,   // op[2:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // status_bits[8:0], hold_mask[15:9],
                                      // port1..port5_duty[55:16], inlet_duty[63:56],
                                      // outlet_duty[71:64], pump1_level[79:72],
                                      // pump2_level[87:80]
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  vphd_pkg::cfg_t    cfg;
  vphd_pkg::item_t   in_item, in_item_q;
  vphd_pkg::result_t result, result_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;
  logic              in_take;

  vphd_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // Unpack the request.
  assign in_item.op         = vphd_pkg::op_e'(s_axis_tuser);
  assign in_item.valve_mask = s_axis_tdata[6:0];
  assign in_item.pump_index = s_axis_tdata[8:7];
  assign in_item.pump_duty  = s_axis_tdata[16:9];

  // The held request moves on when the result register is free or drains.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item;
    end
  end

  vphd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = result_q;

endmodule

/* hdl/vphd_checker.sv */
// Port-level checker for the valve peak-and-hold driver, bound to the top level.
// Depends on valve_peak_hold_driver_assert.svh for the assertion macros.
`include "valve_peak_hold_driver_assert.svh"

module vphd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic        pready
);

  logic [8:0] status_bits;
  logic [6:0] hold_mask;
  logic [7:0] port1_duty;
  logic       pump1_on;
  logic       pump2_on;

  // Result fields as they sit in the stream word.
  assign status_bits = m_axis_tdata[8:0];
  assign hold_mask   = m_axis_tdata[15:9];
  assign port1_duty  = m_axis_tdata[23:16];
  assign pump1_on    = m_axis_tdata[79:72] != 8'd0;
  assign pump2_on    = m_axis_tdata[87:80] != 8'd0;

  // A stalled result keeps its payload.
  `VPHD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")

  // A held valve is always an open valve.
  `VPHD_ASSERT(a_held_open, m_axis_tvalid |-> (hold_mask & ~status_bits[6:0]) == 7'd0, "held valve reported closed")

  // Pump running bits agree with the pump levels.
  `VPHD_ASSERT(a_pump_bits, m_axis_tvalid |-> status_bits[8:7] == {pump2_on, pump1_on}, "pump status mismatch")

  // A closed port valve 1 is reported with zero duty.
  `VPHD_ASSERT(a_port1_duty, m_axis_tvalid && !status_bits[0] |-> port1_duty == 8'd0, "closed valve driven")

  // The configuration port never inserts wait states.
  `VPHD_ASSERT_ALWAYS(a_pready, pready == 1'b1, "pready dropped")

endmodule

bind valve_peak_hold_driver vphd_checker u_vphd_checker (.*);
